[rtl/streaming_top_k_select_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the streaming top-k selector
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef STREAMING_TOP_K_SELECT_ASSERT_SVH
`define STREAMING_TOP_K_SELECT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define STKS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked while reset is asserted.
`define STKS_ASSERT_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/stks_pkg.sv]
// ----------------------------------------------------------------------------
// Streaming top-k selector package
// Word types and fixed field widths shared by the selector modules.
// ----------------------------------------------------------------------------
package stks_pkg;

   localparam int ScoreBits = 32;
   localparam int IndexBits = 24;
   localparam int KeepBits  = 5;
   localparam logic [KeepBits-1:0] KeepReset = 5'd16;

   // Input word: one score and its end-of-vector mark.
   typedef struct packed {
      logic signed [ScoreBits-1:0] score;
      logic                        last;
   } stks_req_type;

   // Result word: one kept entry of a finished vector.
   typedef struct packed {
      logic [IndexBits-1:0]        point_index;
      logic signed [ScoreBits-1:0] kept_score;
      logic                        final_flag;
   } stks_rsp_type;

   // One kept entry as it sits in a cell.
   typedef struct packed {
      logic signed [ScoreBits-1:0] score;
      logic [IndexBits-1:0]        index;
   } stks_entry_type;

   // Per-cell control from the top level.
   typedef struct packed {
      logic shift_en;   // a word is accepted this cycle
      logic active;     // cell lies below the current capacity
      logic valid;      // cell holds an entry of the current vector
   } stks_cell_ctrl_type;

endpackage

[rtl/stks_cell.sv]
// ----------------------------------------------------------------------------
// Top-k insertion cell
// Holds one ranked entry, compares it with the incoming score and either
// keeps it, takes the new entry, or takes its upper neighbor's entry.
// ----------------------------------------------------------------------------
module stks_cell (
   input  logic                        clock,
   input  stks_pkg::stks_cell_ctrl_type ctrl,
   input  stks_pkg::stks_entry_type    new_entry,
   input  logic                        greater_prev,
   input  stks_pkg::stks_entry_type    prev_entry,
   output logic                        greater_self,
   output stks_pkg::stks_entry_type    entry_out,
   output stks_pkg::stks_entry_type    entry_next
);

   stks_pkg::stks_entry_type entry_ff;
   stks_pkg::stks_entry_type entry_in;
   logic                     write_en;

   // An empty cell ranks below anything; equal scores keep the older entry.
   assign greater_self = !ctrl.valid ||
                         ($signed(new_entry.score) > $signed(entry_ff.score));

   always_comb begin
      if (greater_prev) begin
         entry_in = prev_entry;
      end else if (greater_self) begin
         entry_in = new_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   assign write_en   = ctrl.shift_en && ctrl.active;
   assign entry_next = write_en ? entry_in : entry_ff;
   assign entry_out  = entry_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         entry_ff <= entry_in;
      end
   end

endmodule

[rtl/stks_drain.sv]
// ----------------------------------------------------------------------------
// Top-k result drain
// Loads a finished ranking in parallel and shifts it out one entry per
// accepted result word, head first.
// ----------------------------------------------------------------------------
module stks_drain #(
   parameter int MaxKeep = 16,
   parameter int CntW    = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  logic [CntW-1:0]          load_count,
   input  stks_pkg::stks_entry_type load_data [MaxKeep],
   input  logic                     pop,
   output stks_pkg::stks_entry_type head,
   output logic [CntW-1:0]          count
);

   stks_pkg::stks_entry_type entry_ff [MaxKeep];
   logic [CntW-1:0]          count_ff;
   logic [CntW-1:0]          count_in;

   always_comb begin
      count_in = count_ff;
      if (load) begin
         count_in = load_count;
      end else if (pop) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   for (genvar i = 0; i < MaxKeep; i++) begin : g_slot
      if (i == MaxKeep - 1) begin : g_tail
         always_ff @(posedge clock) begin
            if (load) begin
               entry_ff[i] <= load_data[i];
            end
         end
      end else begin : g_body
         always_ff @(posedge clock) begin
            if (load) begin
               entry_ff[i] <= load_data[i];
            end else if (pop) begin
               entry_ff[i] <= entry_ff[i+1];
            end
         end
      end
   end

   assign head  = entry_ff[0];
   assign count = count_ff;

endmodule

[rtl/streaming_top_k_select.sv]
// ----------------------------------------------------------------------------
// Streaming top-k selector
// Keeps the keep_count largest scores of a vector and reports them, largest
// first, when the vector ends.
// ----------------------------------------------------------------------------
// The block takes one score word per clock cycle and numbers each score by its
// position in the vector, starting at zero. A row of MAX_KEEP cells holds the
// kept entries in descending order; every cell compares the incoming score
// with its own in the same cycle, so the row never stalls the input. A new
// score enters freely until keep_count entries are held; after that it must be
// strictly greater than the smallest kept score, and equal scores keep the
// earlier arrival ahead. On the word marked last, that score is ranked like
// any other and the whole ranking is copied into a drain register row, which
// then delivers one result word per cycle unless rsp_stall holds it (largest
// first, final_flag on the last of the run) while the next vector already
// streams into the cells. The only input stall is a last word that arrives
// while the previous run still has words to deliver, unless its final word is
// taken in that same cycle; it waits until the drain can take the new ranking.
// keep_count is written through the csr_ port; the user must write it only
// while the block is idle; the block itself does not enforce this. Zero
// acts as one and values above MAX_KEEP act as MAX_KEEP. Positions wrap at 2^24.
// ----------------------------------------------------------------------------
module streaming_top_k_select #(
   parameter int MAX_KEEP = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  stks_pkg::stks_req_type                 req_word,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output stks_pkg::stks_rsp_type                 rsp_word,
   input  logic                                   csr_write_en,
   input  logic [stks_pkg::KeepBits-1:0]          csr_write_data
);

   localparam int CntW = $clog2(MAX_KEEP + 1);
   localparam int CmpW = (CntW > stks_pkg::KeepBits) ? CntW : stks_pkg::KeepBits;

   // Configuration register.
   logic [stks_pkg::KeepBits-1:0] keep_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_count_ff <= stks_pkg::KeepReset;
      end else if (csr_write_en) begin
         keep_count_ff <= csr_write_data;
      end
   end

   // Effective capacity: keep_count clamped to the range one to MAX_KEEP.
   logic [CmpW-1:0] keep_wide;
   logic [CmpW-1:0] cap_wide;
   logic [CntW-1:0] cap;

   assign keep_wide = CmpW'(keep_count_ff);

   always_comb begin
      if (keep_wide == '0) begin
         cap_wide = CmpW'(1);
      end else if (keep_wide > CmpW'(MAX_KEEP)) begin
         cap_wide = CmpW'(MAX_KEEP);
      end else begin
         cap_wide = keep_wide;
      end
   end

   assign cap = cap_wide[CntW-1:0];

   // Fill level and position counter of the vector in progress.
   logic [CntW-1:0]                fill_ff;
   logic [CntW-1:0]                fill_in;
   logic [CntW-1:0]                fill_eff;
   logic [CntW-1:0]                fill_next;
   logic [stks_pkg::IndexBits-1:0] position_ff;
   logic [stks_pkg::IndexBits-1:0] position_in;
   logic                           req_accept;
   logic                           drain_load;
   logic                           drain_ready;
   logic                           rsp_accept;
   logic [CntW-1:0]                drain_count;

   // A lowered keep_count trims the held list to the new capacity.
   assign fill_eff  = (fill_ff > cap) ? cap : fill_ff;
   assign fill_next = (fill_eff < cap) ? (fill_eff + CntW'(1)) : fill_eff;

   assign rsp_accept  = rsp_valid && !rsp_stall;
   assign drain_ready = (drain_count == '0) ||
                        ((drain_count == CntW'(1)) && !rsp_stall);
   assign req_stall   = req_word.last && !drain_ready;
   assign req_accept  = req_valid && !req_stall;
   assign drain_load  = req_accept && req_word.last;

   always_comb begin
      fill_in     = fill_ff;
      position_in = position_ff;
      if (req_accept) begin
         if (req_word.last) begin
            fill_in     = '0;
            position_in = '0;
         end else begin
            fill_in     = fill_next;
            position_in = position_ff + stks_pkg::IndexBits'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         position_ff <= '0;
      end else begin
         fill_ff     <= fill_in;
         position_ff <= position_in;
      end
   end

   // Row of insertion cells, highest score at cell zero.
   stks_pkg::stks_entry_type new_entry;
   stks_pkg::stks_entry_type cell_entry [MAX_KEEP];
   stks_pkg::stks_entry_type cell_next  [MAX_KEEP];
   logic [MAX_KEEP-1:0]      cell_greater;

   assign new_entry.score = req_word.score;
   assign new_entry.index = position_ff;

   for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
      stks_pkg::stks_cell_ctrl_type ctrl;
      logic                         greater_prev;
      stks_pkg::stks_entry_type     prev_entry;

      assign ctrl.shift_en = req_accept;
      assign ctrl.active   = CntW'(i) < cap;
      assign ctrl.valid    = CntW'(i) < fill_eff;

      if (i == 0) begin : g_head
         assign greater_prev = 1'b0;
         assign prev_entry   = new_entry;
      end else begin : g_link
         assign greater_prev = cell_greater[i-1];
         assign prev_entry   = cell_entry[i-1];
      end

      stks_cell u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .new_entry    (new_entry),
         .greater_prev (greater_prev),
         .prev_entry   (prev_entry),
         .greater_self (cell_greater[i]),
         .entry_out    (cell_entry[i]),
         .entry_next   (cell_next[i])
      );
   end

   // Result drain: loaded with the ranking as it stands after the last word.
   stks_pkg::stks_entry_type drain_head;

   stks_drain #(
      .MaxKeep (MAX_KEEP),
      .CntW    (CntW)
   ) u_drain (
      .clock      (clock),
      .reset      (reset),
      .load       (drain_load),
      .load_count (fill_next),
      .load_data  (cell_next),
      .pop        (rsp_accept),
      .head       (drain_head),
      .count      (drain_count)
   );

   assign rsp_valid            = drain_count != '0;
   assign rsp_word.point_index = drain_head.index;
   assign rsp_word.kept_score  = drain_head.score;
   assign rsp_word.final_flag  = drain_count == CntW'(1);

endmodule

[rtl/stks_checker.sv]
// ----------------------------------------------------------------------------
// Streaming top-k selector port checker
// Watches the selector's ports for handshake and run-sequencing slips.
// ----------------------------------------------------------------------------
`include "streaming_top_k_select_assert.svh"

module stks_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  stks_pkg::stks_req_type req_word,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  stks_pkg::stks_rsp_type rsp_word
);

   logic req_last_taken;
   logic rsp_taken;

   assign req_last_taken = req_valid && !req_stall && req_word.last;
   assign rsp_taken      = rsp_valid && !rsp_stall;

   `STKS_ASSERT_NEXT(a_reset_quiet, clock, reset, !rsp_valid, "result word valid after reset")
   `STKS_ASSERT_IMPL(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, ##1 (rsp_valid && $stable(rsp_word)), "stalled result word changed")
   `STKS_ASSERT_IMPL(a_run_continues, clock, reset, rsp_taken && !rsp_word.final_flag, ##1 rsp_valid, "run ended before its final word")
   `STKS_ASSERT_IMPL(a_no_overlap, clock, reset, req_last_taken, !rsp_valid || (rsp_word.final_flag && !rsp_stall), "vector ended while a run was still pending")
   `STKS_ASSERT_IMPL(a_last_reports, clock, reset, req_last_taken, ##1 rsp_valid, "vector end gave no result")

endmodule

bind streaming_top_k_select stks_checker u_stks_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Streaming top-k selector testbench
// Streams score vectors through the selector under random idling on both
// sides and checks every reported entry against a cycle-free ranking model.
// ----------------------------------------------------------------------------
// A short directed table runs first: extreme scores, ties at the capacity
// boundary, short vectors and every class of keep_count value, including zero
// and values above the cell count. Single-word vectors and the keep_count-zero
// vector carry their expected result in the table; all other rows, and the
// random vectors that follow, are checked against the ranking model below.
// During the random part the result side holds off once for a long stretch
// so that the drain row backs up and the input side has to stall on a last word.
// ----------------------------------------------------------------------------
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_KEEP       = 16;
   localparam int IDLE_PERCENT   = 11;
   localparam int SETTLE_CYCLES  = 20;    // one drain word per cycle, if unstalled
   localparam int HOLD_CYCLES    = 400;   // long result-side hold-off
   localparam int WATCHDOG_LIMIT = 3000;  // cycles with no word moving on either side
   localparam int RANDOM_WORDS   = 330;
   localparam int ROW_COUNT      = 30;

   typedef enum logic [1:0] {
      ROW_WORD,   // offer one score word
      ROW_KEEP    // write keep_count once the block has gone idle
   } row_kind_type;

   typedef enum logic [1:0] {
      STYLE_WIDE,     // any 32-bit score
      STYLE_TIES,     // a handful of small values, so equal scores are common
      STYLE_RAMP,     // steadily rising or falling scores
      STYLE_EXTREME   // the corners of the Q16.16 range
   } score_style_type;

   typedef struct packed {
      row_kind_type                  kind;
      logic [stks_pkg::KeepBits-1:0] keep;
      logic signed [31:0]            score;
      logic                          last;
      logic                          typed;       // expected result given in the row
      stks_pkg::stks_rsp_type        typed_rsp;
   } stim_row_type;

   // Directed stimulus. keep_count is still at its reset value of 16 for the
   // first rows.
   stim_row_type directed_rows [ROW_COUNT] = '{
      // Single-word vectors at the extremes report themselves at position 0.
      '{ROW_WORD, 5'd0, 32'sh7FFFFFFF, 1'b1, 1'b1, '{24'd0, 32'sh7FFFFFFF, 1'b1}},
      '{ROW_WORD, 5'd0, 32'sh80000000, 1'b1, 1'b1, '{24'd0, 32'sh80000000, 1'b1}},
      '{ROW_WORD, 5'd0, 32'sd0,        1'b1, 1'b1, '{24'd0, 32'sd0,        1'b1}},
      '{ROW_WORD, 5'd0, -32'sd1,       1'b1, 1'b1, '{24'd0, -32'sd1,       1'b1}},
      // Equal scores must keep arrival order.
      '{ROW_WORD, 5'd0, 32'sd5,        1'b0, 1'b0, '0},
      '{ROW_WORD, 5'd0, 32'sd5,        1'b0, 1'b0, '0},
      '{ROW_WORD, 5'd0, 32'sd3,        1'b0, 1'b0, '0},
      '{ROW_WORD, 5'd0, 32'sd5,        1'b0, 1'b0, '0},
      '{ROW_WORD, 5'd0, 32'sd7,        1'b1, 1'b0, '0},
      // Two cells: a score equal to the smallest kept one is turned away.
      '{ROW_KEEP, 5'd2, 32'sd0,        1'b0, 1'b0, '0},
      '{ROW_WORD, 5'd0, 32'sd1,        1'b0, 1'b0, '0},
      '{ROW_WORD, 5'd0, 32'sd3,        1'b0, 1'b0, '0},
      '{ROW_WORD, 5'd0, 32'sd3,        1'b0, 1'b0, '0},
      '{ROW_WORD, 5'd0, 32'sd2,        1'b0, 1'b0, '0},
      '{ROW_WORD, 5'd0, 32'sd3,        1'b1, 1'b0, '0},
      // A keep_count of zero acts as one.
      '{ROW_KEEP, 5'd0, 32'sd0,        1'b0, 1'b0, '0},
      '{ROW_WORD, 5'd0, -32'sd5,       1'b0, 1'b0, '0},
      '{ROW_WORD, 5'd0, 32'sd10,       1'b1, 1'b1, '{24'd1, 32'sd10,       1'b1}},
      // The largest register value saturates at the cell count.
      '{ROW_KEEP, 5'd31, 32'sd0,       1'b0, 1'b0, '0},
      '{ROW_WORD, 5'd0, 32'sh00010000, 1'b0, 1'b0, '0},
      '{ROW_WORD, 5'd0, 32'sh80000000, 1'b0, 1'b0, '0},
      '{ROW_WORD, 5'd0, 32'sh7FFFFFFF, 1'b1, 1'b0, '0},
      '{ROW_KEEP, 5'd1, 32'sd0,        1'b0, 1'b0, '0},
      '{ROW_WORD, 5'd0, 32'sh00008000, 1'b0, 1'b0, '0},
      '{ROW_WORD, 5'd0, 32'sh7FFFFFFF, 1'b0, 1'b0, '0},
      '{ROW_WORD, 5'd0, 32'sh7FFFFFFF, 1'b1, 1'b0, '0},
      '{ROW_KEEP, 5'd16, 32'sd0,       1'b0, 1'b0, '0},
      '{ROW_WORD, 5'd0, 32'shAAAAAAAA, 1'b0, 1'b0, '0},
      '{ROW_WORD, 5'd0, 32'sh55555555, 1'b0, 1'b0, '0},
      '{ROW_WORD, 5'd0, 32'sh80000000, 1'b1, 1'b0, '0}
   };

   // Keep counts walked by the random phases before they turn fully random.
   int keep_plan [6] = '{1, 31, 0, 16, 17, 2};

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   stks_pkg::stks_req_type        req_word = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   stks_pkg::stks_rsp_type        rsp_word;
   logic                          csr_write_en = 1'b0;
   logic [stks_pkg::KeepBits-1:0] csr_write_data = '0;

   // Ranking model state.
   logic signed [31:0]             kept_scores [MAX_KEEP];
   logic [stks_pkg::IndexBits-1:0] kept_points [MAX_KEEP];
   int                             held_count = 0;
   logic [stks_pkg::IndexBits-1:0] next_point = '0;
   logic [stks_pkg::KeepBits-1:0]  keep_count = stks_pkg::KeepReset;
   stks_pkg::stks_rsp_type         ranked_out [MAX_KEEP];

   stks_pkg::stks_rsp_type expected_results [$];
   int           error_count = 0;
   int           idle_cycles = 0;
   int unsigned  cycle_count = 0;
   bit           hold_request = 1'b0;
   bit           hold_done = 1'b0;

   streaming_top_k_select #(
      .MAX_KEEP(MAX_KEEP)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_word       (req_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_word       (rsp_word),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // quiet_stretch marks the part of the run in which neither side idles.
   function automatic bit quiet_stretch();
      return (cycle_count % 1000) >= 700;
   endfunction

   function automatic int keep_capacity();
      if (keep_count == 0) begin
         return 1;
      end
      if (keep_count > MAX_KEEP) begin
         return MAX_KEEP;
      end
      return int'(keep_count);
   endfunction

   // Ranks one accepted score. On a last word the finished ranking is copied
   // to ranked_out, the entry count is returned and the vector starts over.
   function automatic int rank_score(stks_pkg::stks_req_type word);
      int cap;
      int fill;
      int slot;
      int limit;
      int n;
      int i;
      cap  = keep_capacity();
      fill = (held_count > cap) ? cap : held_count;
      slot = 0;
      // A new score lands behind every kept score that is equal or greater.
      while (slot < fill && $signed(kept_scores[slot]) >= $signed(word.score)) begin
         slot++;
      end
      if (fill < cap) begin
         limit = fill;
         fill++;
      end else begin
         limit = cap - 1;
      end
      if (slot < cap) begin
         for (i = limit; i > slot; i--) begin
            kept_scores[i] = kept_scores[i-1];
            kept_points[i] = kept_points[i-1];
         end
         kept_scores[slot] = word.score;
         kept_points[slot] = next_point;
      end
      held_count = fill;
      next_point = next_point + 1'b1;
      if (!word.last) begin
         return 0;
      end
      n = (held_count > cap) ? cap : held_count;
      for (i = 0; i < n; i++) begin
         ranked_out[i].point_index = kept_points[i];
         ranked_out[i].kept_score  = kept_scores[i];
         ranked_out[i].final_flag  = (i == n - 1);
      end
      held_count = 0;
      next_point = '0;
      return n;
   endfunction

   function automatic logic signed [31:0] pick_score(score_style_type style, int pos,
                                                     logic signed [31:0] base,
                                                     logic signed [31:0] step);
      int t;
      case (style)
         STYLE_TIES: begin
            t = $urandom_range(6);
            return t - 3;
         end
         STYLE_RAMP: begin
            return base + step * 32'(pos);
         end
         STYLE_EXTREME: begin
            case ($urandom_range(4))
               0: return 32'sh80000000;
               1: return 32'sh7FFFFFFF;
               2: return 32'sd0;
               3: return -32'sd1;
               default: return 32'sd1;
            endcase
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   // Offers one word and returns at the edge where it is taken. Valid stays
   // high afterwards; an idle step of a later offer or wait_idle lowers it.
   task automatic offer_word(input stks_pkg::stks_req_type word);
      while (!quiet_stretch() && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_word  <= word;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   task automatic take_word(input stks_pkg::stks_req_type word, input bit typed,
                            input stks_pkg::stks_rsp_type typed_rsp);
      int n;
      int k;
      offer_word(word);
      n = rank_score(word);
      if (typed) begin
         expected_results.push_back(typed_rsp);
      end else begin
         for (k = 0; k < n; k++) begin
            expected_results.push_back(ranked_out[k]);
         end
      end
   endtask

   // Lowers valid and waits for the block to drain completely.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_keep(input logic [stks_pkg::KeepBits-1:0] value);
      wait_idle();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      keep_count = value;
   endtask

   task automatic flag_error(input string msg);
      if (error_count < 10) begin
         $display("%0t: %s", $realtime, msg);
      end
      error_count++;
   endtask

   // Result checker: every accepted word is matched against the oldest
   // outstanding expectation.
   always @(posedge clock) begin
      stks_pkg::stks_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            flag_error($sformatf("unexpected result index=%0d score=%0d final=%0d",
                                 rsp_word.point_index, rsp_word.kept_score,
                                 rsp_word.final_flag));
         end else begin
            want = expected_results.pop_front();
            if (rsp_word.point_index !== want.point_index ||
                rsp_word.kept_score  !== want.kept_score  ||
                rsp_word.final_flag  !== want.final_flag) begin
               flag_error($sformatf(
                  "mismatch: expected index=%0d score=%0d final=%0d, got %0d %0d %0d",
                  want.point_index, want.kept_score, want.final_flag,
                  rsp_word.point_index, rsp_word.kept_score, rsp_word.final_flag));
            end
         end
      end
   end

   // Result side: random stalls, plus one long hold-off when requested so
   // that the drain row fills and a last word has to wait at the input.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= !quiet_stretch() && ($urandom_range(99) < IDLE_PERCENT);
      end
   end

   // Watchdog on cycles in which no word moves in either direction.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      stks_pkg::stks_req_type word;
      stks_pkg::stks_rsp_type none;
      score_style_type        style;
      logic signed [31:0]     ramp_base;
      logic signed [31:0]     ramp_step;
      int                     random_words;
      int                     phase;
      int                     vec;
      int                     vec_len;
      int                     pos;
      none = '0;
      random_words = 0;
      phase = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < ROW_COUNT; r++) begin
         if (directed_rows[r].kind == ROW_KEEP) begin
            write_keep(directed_rows[r].keep);
         end else begin
            word.score = directed_rows[r].score;
            word.last  = directed_rows[r].last;
            take_word(word, directed_rows[r].typed, directed_rows[r].typed_rsp);
         end
      end

      // Random phases: a keep_count setting, then four back-to-back vectors.
      while (random_words < RANDOM_WORDS) begin
         if (phase < 6) begin
            write_keep(stks_pkg::KeepBits'(keep_plan[phase]));
         end else begin
            write_keep(stks_pkg::KeepBits'($urandom_range(31)));
         end
         if (phase == 2) begin
            hold_request = 1'b1;
         end
         for (vec = 0; vec < 4; vec++) begin
            // Mostly short vectors; some run well past the cell count.
            vec_len = ($urandom_range(7) == 0) ? $urandom_range(17, 40)
                                               : $urandom_range(1, 20);
            style     = score_style_type'($urandom_range(3));
            ramp_base = $urandom;
            ramp_step = $urandom_range(1) ? 32'sh00000100 : -32'sh00000100;
            for (pos = 0; pos < vec_len; pos++) begin
               word.score = pick_score(style, pos, ramp_base, ramp_step);
               word.last  = (pos == vec_len - 1);
               take_word(word, 1'b0, none);
               random_words++;
            end
         end
         phase++;
      end

      wait_idle();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[streaming_top_k_select.f]
+incdir+rtl
rtl/stks_pkg.sv
rtl/stks_cell.sv
rtl/stks_drain.sv
rtl/streaming_top_k_select.sv
rtl/stks_checker.sv
tb/testbench.sv
